// ===== src/cmrps_pkg.sv =====
// Shared constants and types for the Catmull-Rom path sampler.
package cmrps_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_MAX_SAMPLES = 31;

    // samples-per-segment register
    localparam int SPS_WIDTH = 5;
    localparam logic [SPS_WIDTH-1:0] SPS_RESET = 5'd20;

    // curve parameter t is an unsigned Q0.16 fraction, one extra bit of headroom
    localparam int T_FRAC  = 16;
    localparam int T_WIDTH = T_FRAC + 1;

    // accumulator guard bits above the coordinate width
    localparam int ACC_GUARD = 6;

    typedef enum logic [2:0] {
        ST_DIV,
        ST_IDLE,
        ST_LOADB,
        ST_COEF1,
        ST_COEF2,
        ST_CALC,
        ST_POINT
    } t_state;

    typedef struct packed {
        logic div_start;
        logic clear;
        logic advance;
    } t_tgen_ctl;

endpackage

// ===== src/cmrps_if.sv =====
// Waypoint and sample channel interfaces for the Catmull-Rom path sampler.
interface cmrps_pt_if import cmrps_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          final_point;

    modport source (output valid, point_x, point_y, final_point, input ready);
    modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

interface cmrps_smp_if import cmrps_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic                          last_of_run;
    logic                          path_end;

    modport source (output valid, out_x, out_y, last_of_run, path_end, input ready);
    modport sink   (input valid, out_x, out_y, last_of_run, path_end, output ready);
endinterface

// ===== src/cmrps_tgen.sv =====
// Curve parameter generator: serial divide of 65536 by N, then t = floor(s*65536/N) by steps.
module cmrps_tgen import cmrps_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    localparam int NW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [NW-1:0]      i_n,
    input  t_tgen_ctl          i_ctl,
    output logic               o_busy,
    output logic [T_WIDTH-1:0] o_t
);

    localparam int CW = $clog2(T_WIDTH);

    logic               r_busy;
    logic [CW-1:0]      r_dcnt;
    logic [NW-1:0]      r_drem;
    logic [T_WIDTH-1:0] r_q;
    logic [T_WIDTH-1:0] r_t;
    logic [NW-1:0]      r_trem;

    logic [NW:0] w_sh;
    logic [NW:0] w_sum;
    logic        w_ge;
    logic        w_carry;

    // dividend is a single one followed by T_FRAC zeros, fed MSB first
    assign w_sh    = {r_drem, (r_dcnt == '0)};
    assign w_ge    = w_sh >= {1'b0, i_n};
    assign w_sum   = {1'b0, r_trem} + {1'b0, r_drem};
    assign w_carry = w_sum >= {1'b0, i_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.div_start) begin
            r_busy <= 1'b1;
            r_dcnt <= '0;
            r_drem <= '0;
        end else if (r_busy) begin
            r_drem <= NW'(w_ge ? (w_sh - {1'b0, i_n}) : w_sh);
            r_dcnt <= r_dcnt + 1'b1;
            if (r_dcnt == CW'(T_WIDTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_q <= {r_q[T_WIDTH-2:0], w_ge};
        end
        // quotient step plus carry from the running remainder
        if (i_ctl.clear) begin
            r_t    <= '0;
            r_trem <= '0;
        end else if (i_ctl.advance) begin
            r_t    <= r_t + r_q + T_WIDTH'(w_carry);
            r_trem <= NW'(w_carry ? (w_sum - {1'b0, i_n}) : w_sum);
        end
    end

    assign o_busy = r_busy;
    assign o_t    = r_t;

endmodule

// ===== src/cmrps_mac.sv =====
// Shared multiply-accumulate unit: acc = addend + floor(mult * t / 65536).
module cmrps_mac import cmrps_pkg::*; #(
    parameter int ACC_WIDTH = DEF_COORD_WIDTH + ACC_GUARD
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [ACC_WIDTH-1:0] i_addend,
    input  logic signed [ACC_WIDTH-1:0] i_mult,
    input  logic        [T_WIDTH-1:0]   i_t,
    output logic signed [ACC_WIDTH-1:0] o_acc
);

    localparam int PW = ACC_WIDTH + T_WIDTH + 1;

    logic signed [PW-1:0]        w_prod;
    logic signed [ACC_WIDTH-1:0] w_scaled;
    logic signed [ACC_WIDTH-1:0] r_acc;

    assign w_prod   = i_mult * $signed({1'b0, i_t});
    // dropping the low bits of a two's complement product is a floor
    assign w_scaled = $signed(w_prod[ACC_WIDTH+T_FRAC-1:T_FRAC]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= i_addend + w_scaled;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== src/catmull_rom_path_sampler_top.sv =====
// Catmull-Rom path sampler top level: waypoint history, sequencer and output register.
//
//  channel   dir  handshake        payload
//  i_pt      in   valid/ready      point_x, point_y, final_point
//  o_smp     out  valid/ready      out_x, out_y, last_of_run, path_end
//  cfg       in   i_cfg_we         i_cfg_wdata (samples per segment)
//
//  Each sample is six passes through the shared multiply-add (Horner for x, then y) and one
//  write into the output register. A segment sets up coefficients in ST_COEF1 and ST_COEF2
//  (ST_LOADB first for the closing segment), the copied end point is written in ST_POINT and
//  a waypoint is accepted in ST_IDLE. After reset and each register write, 65536/N is divided
//  out bit-serially with i_pt.ready low. An output stall holds the sequencer at its write step.
module catmull_rom_path_sampler_top import cmrps_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SPS_WIDTH-1:0] i_cfg_wdata,
    cmrps_pt_if.sink             i_pt,
    cmrps_smp_if.source          o_smp
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = COORD_WIDTH + ACC_GUARD;
    localparam int NW = $clog2(MAX_SAMPLES + 1);

    localparam logic [2:0] STEP_X_CB = 3'd0;
    localparam logic [2:0] STEP_X_A  = 3'd1;
    localparam logic [2:0] STEP_X_P1 = 3'd2;
    localparam logic [2:0] STEP_Y_CB = 3'd3;
    localparam logic [2:0] STEP_Y_A  = 3'd4;
    localparam logic [2:0] STEP_Y_P1 = 3'd5;
    localparam logic [2:0] STEP_WRITE = 3'd6;

    localparam logic signed [AW-2:0] HALF_MAX = {{(AW-1-W){1'b0}}, 1'b0, {(W-1){1'b1}}};
    localparam logic signed [AW-2:0] HALF_MIN = {{(AW-W){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  OUT_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  OUT_MIN  = {1'b1, {(W-1){1'b0}}};

    // halve with floor, then clamp to the coordinate range
    function automatic logic signed [W-1:0] f_sat(input logic signed [AW-1:0] v);
        logic signed [AW-2:0] h;
        h = $signed(v[AW-1:1]);
        if (h > HALF_MAX) begin
            return OUT_MAX;
        end else if (h < HALF_MIN) begin
            return OUT_MIN;
        end
        return h[W-1:0];
    endfunction

    t_state               r_state, n_state;
    logic [2:0]           r_step;
    logic [NW-1:0]        r_s;
    logic [SPS_WIDTH-1:0] r_sps;
    logic [1:0]           r_cnt;
    logic [1:0]           r_c;
    logic                 r_fin;
    logic                 r_seg_b;
    logic                 r_ovalid;

    logic signed [W-1:0]  r_hist [2][3];
    logic signed [W-1:0]  r_pt [2];
    logic signed [W-1:0]  r_p [2][4];
    logic signed [AW-1:0] r_ca [2];
    logic signed [AW-1:0] r_cb [2];
    logic signed [AW-1:0] r_cc [2];
    logic signed [AW-1:0] r_s1 [2];
    logic signed [AW-1:0] r_s2 [2];
    logic signed [AW-1:0] r_u [2];
    logic signed [AW-1:0] r_v [2];
    logic signed [W-1:0]  r_res_x;
    logic signed [W-1:0]  r_ox;
    logic signed [W-1:0]  r_oy;
    logic                 r_olast;
    logic                 r_oend;

    logic signed [W-1:0]  w_in [2];
    logic signed [AW-1:0] w_d [2];
    logic [NW-1:0]        w_n;
    logic                 w_nz;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_last_s;
    logic                 w_busy;
    logic [T_WIDTH-1:0]   w_t;
    logic signed [AW-1:0] w_acc;
    logic signed [AW-1:0] w_add;
    logic signed [AW-1:0] w_mul;
    logic                 w_ax;
    logic                 w_mac_en;
    logic                 w_ready;
    logic                 w_wr_smp;
    logic                 w_wr_pt;
    t_tgen_ctl            w_ctl;

    assign w_in[0] = i_pt.point_x;
    assign w_in[1] = i_pt.point_y;

    assign w_n        = (r_sps > SPS_WIDTH'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : NW'(r_sps);
    assign w_nz       = (w_n != '0);
    assign w_accept   = i_pt.valid && w_ready;
    assign w_out_free = !r_ovalid || o_smp.ready;
    assign w_last_s   = ((r_s + NW'(1)) == w_n);
    assign w_ax       = (r_step >= STEP_Y_CB);

    cmrps_tgen #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_tgen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_n     (w_n),
        .i_ctl   (w_ctl),
        .o_busy  (w_busy),
        .o_t     (w_t)
    );

    cmrps_mac #(
        .ACC_WIDTH (AW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_en     (w_mac_en),
        .i_addend (w_add),
        .i_mult   (w_mul),
        .i_t      (w_t),
        .o_acc    (w_acc)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_DIV: begin
                if (!w_busy && !i_cfg_we) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cfg_we) begin
                    n_state = ST_DIV;
                end else if (w_accept) begin
                    if (w_nz && r_cnt >= 2'd2) begin
                        n_state = ST_COEF1;
                    end else if (w_nz && i_pt.final_point && r_cnt != 2'd0) begin
                        n_state = ST_LOADB;
                    end else if (i_pt.final_point) begin
                        n_state = ST_POINT;
                    end
                end
            end
            ST_LOADB: n_state = ST_COEF1;
            ST_COEF1: n_state = ST_COEF2;
            ST_COEF2: n_state = ST_CALC;
            ST_CALC: begin
                if (r_step == STEP_WRITE && w_out_free && w_last_s) begin
                    if (!r_seg_b && r_fin && r_c != 2'd0) begin
                        n_state = ST_LOADB;
                    end else if (r_fin) begin
                        n_state = ST_POINT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_POINT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_DIV;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ready         = 1'b0;
        w_mac_en        = 1'b0;
        w_add           = '0;
        w_mul           = '0;
        w_wr_smp        = 1'b0;
        w_wr_pt         = 1'b0;
        w_ctl           = '0;
        w_ctl.div_start = i_cfg_we;
        unique case (r_state)
            ST_DIV:   ;
            ST_IDLE:  w_ready = !i_cfg_we;
            ST_LOADB: ;
            ST_COEF1: w_ctl.clear = 1'b1;
            ST_COEF2: ;
            ST_CALC: begin
                if (r_step == STEP_WRITE) begin
                    w_wr_smp      = w_out_free;
                    w_ctl.advance = w_out_free && !w_last_s;
                end else begin
                    w_mac_en = 1'b1;
                    case (r_step) inside
                        STEP_X_CB, STEP_Y_CB: begin
                            w_add = r_cb[w_ax];
                            w_mul = r_cc[w_ax];
                        end
                        STEP_X_A, STEP_Y_A: begin
                            w_add = r_ca[w_ax];
                            w_mul = w_acc;
                        end
                        STEP_X_P1, STEP_Y_P1: begin
                            w_add = AW'(r_p[w_ax][1]) <<< 1;
                            w_mul = w_acc;
                        end
                        default: ;
                    endcase
                end
            end
            ST_POINT: w_wr_pt = w_out_free;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_DIV;
            r_step   <= '0;
            r_s      <= '0;
            r_sps    <= SPS_RESET;
            r_cnt    <= '0;
            r_c      <= '0;
            r_fin    <= 1'b0;
            r_seg_b  <= 1'b0;
            r_ovalid <= 1'b0;
            for (int ax = 0; ax < 2; ax++) begin
                for (int i = 0; i < 3; i++) begin
                    r_hist[ax][i] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_sps <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_c     <= r_cnt;
                r_fin   <= i_pt.final_point;
                r_seg_b <= 1'b0;
                if (i_pt.final_point) begin
                    r_cnt <= '0;
                end else begin
                    for (int ax = 0; ax < 2; ax++) begin
                        r_hist[ax][0] <= r_hist[ax][1];
                        r_hist[ax][1] <= r_hist[ax][2];
                        r_hist[ax][2] <= w_in[ax];
                    end
                    if (r_cnt != 2'd3) begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
            end
            if (r_state == ST_LOADB) begin
                r_seg_b <= 1'b1;
            end
            if (r_state == ST_COEF1) begin
                r_s <= '0;
            end
            if (r_state == ST_COEF2) begin
                r_step <= STEP_X_CB;
            end else if (r_state == ST_CALC) begin
                if (r_step != STEP_WRITE) begin
                    r_step <= r_step + 3'd1;
                end else if (w_out_free) begin
                    r_step <= STEP_X_CB;
                    r_s    <= r_s + NW'(1);
                end
            end
            if (w_wr_smp || w_wr_pt) begin
                r_ovalid <= 1'b1;
            end else if (o_smp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    for (genvar ax = 0; ax < 2; ax++) begin : g_diff
        assign w_d[ax] = AW'(r_p[ax][1]) - AW'(r_p[ax][2]);
    end

    // segment points, coefficients and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int ax = 0; ax < 2; ax++) begin
                r_pt[ax]   <= w_in[ax];
                // first segment of a path clamps p0 to p1
                r_p[ax][0] <= (r_cnt == 2'd3) ? r_hist[ax][0] : r_hist[ax][1];
                r_p[ax][1] <= r_hist[ax][1];
                r_p[ax][2] <= r_hist[ax][2];
                r_p[ax][3] <= w_in[ax];
            end
        end
        if (r_state == ST_LOADB) begin
            for (int ax = 0; ax < 2; ax++) begin
                r_p[ax][0] <= (r_c >= 2'd2) ? r_hist[ax][1] : r_hist[ax][2];
                r_p[ax][1] <= r_hist[ax][2];
                r_p[ax][2] <= r_pt[ax];
                r_p[ax][3] <= r_pt[ax];
            end
        end
        if (r_state == ST_COEF1) begin
            for (int ax = 0; ax < 2; ax++) begin
                r_ca[ax] <= AW'(r_p[ax][2]) - AW'(r_p[ax][0]);
                r_s1[ax] <= (AW'(r_p[ax][0]) <<< 1) + (AW'(r_p[ax][2]) <<< 2);
                r_s2[ax] <= (AW'(r_p[ax][1]) <<< 2) + AW'(r_p[ax][1]) + AW'(r_p[ax][3]);
                r_u[ax]  <= w_d[ax] + (w_d[ax] <<< 1);
                r_v[ax]  <= AW'(r_p[ax][3]) - AW'(r_p[ax][0]);
            end
        end
        if (r_state == ST_COEF2) begin
            for (int ax = 0; ax < 2; ax++) begin
                r_cb[ax] <= r_s1[ax] - r_s2[ax];
                r_cc[ax] <= r_u[ax] + r_v[ax];
            end
        end
        // x result sits in the accumulator as the y pass starts
        if (r_state == ST_CALC && r_step == STEP_Y_CB) begin
            r_res_x <= f_sat(w_acc);
        end
        if (w_wr_smp) begin
            r_ox    <= r_res_x;
            r_oy    <= f_sat(w_acc);
            r_olast <= w_last_s && !r_fin;
            r_oend  <= 1'b0;
        end else if (w_wr_pt) begin
            r_ox    <= r_pt[0];
            r_oy    <= r_pt[1];
            r_olast <= 1'b1;
            r_oend  <= 1'b1;
        end
    end

    assign i_pt.ready        = w_ready;
    assign o_smp.valid       = r_ovalid;
    assign o_smp.out_x       = r_ox;
    assign o_smp.out_y       = r_oy;
    assign o_smp.last_of_run = r_olast;
    assign o_smp.path_end    = r_oend;

endmodule
